// ===== hdl/ipatv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP address text validator package
// Character codes, limits, result codes and shared types for the validator.
// ----------------------------------------------------------------------------
package ipatv_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    // Counter saturation points and limits.
    localparam logic [3:0] SEP_COUNT_SAT   = 4'd8;
    localparam logic [5:0] CHAR_COUNT_SAT  = 6'd40;
    localparam logic [5:0] V4_MAX_CHARS    = 6'd15;
    localparam logic [5:0] V6_MAX_CHARS    = 6'd39;
    localparam logic [3:0] V4_SEPARATORS   = 4'd3;
    localparam logic [3:0] V6_SEPARATORS   = 4'd7;
    localparam logic [8:0] V4_SEG_MAX      = 9'd255;
    localparam logic [8:0] V4_VALUE_SAT    = 9'd256;
    localparam logic [1:0] V4_DIGITS_SAT   = 2'd2;
    localparam logic [2:0] V6_GROUP_MAX    = 3'd4;
    localparam logic [2:0] V6_DIGITS_SAT   = 3'd5;

    // Verdict codes.
    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_V4   = 2'd1;
    localparam logic [1:0] VERDICT_V6   = 2'd2;

    // One registered character on its way to the scanner.
    typedef struct packed {
        logic       valid;
        logic [7:0] char_code;
        logic       last;
    } char_stage_t;

    // Running state of the scan over one address text.
    typedef struct packed {
        logic [3:0] sep_count;
        logic [5:0] char_count;
        logic       v4_valid;
        logic [8:0] v4_value;
        logic [1:0] v4_digits;
        logic       v4_lead_zero;
        logic       v6_valid;
        logic [2:0] v6_digits;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        sep_count:    4'd0,
        char_count:   6'd0,
        v4_valid:     1'b1,
        v4_value:     9'd0,
        v4_digits:    2'd0,
        v4_lead_zero: 1'b0,
        v6_valid:     1'b1,
        v6_digits:    3'd0
    };

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c)
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F))
            || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
    endfunction

endpackage

// ===== hdl/ipatv_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Captures one character request and holds it until the scanner takes it.
// ----------------------------------------------------------------------------
module ipatv_in_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    input  logic                   advance,
    output ipatv_pkg::char_stage_t stage
);
    import ipatv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    // The register can take a new request when it is empty or being drained.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.char_code = char_reg;
    assign stage.last      = last_reg;

endmodule

// ===== hdl/ipatv_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address scanner
// Updates the IPv4 and IPv6 checks for each character and forms the verdict.
// ----------------------------------------------------------------------------
module ipatv_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  ipatv_pkg::char_stage_t stage,
    output logic [1:0]             verdict_next
);
    import ipatv_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t mid;

    logic        c_dot;
    logic        c_colon;
    logic        c_dec;
    logic        c_hex;
    logic [11:0] v4_prod;
    logic        v4_final_ok;
    logic        v6_final_ok;

    assign c_dot   = (stage.char_code == CHAR_DOT);
    assign c_colon = (stage.char_code == CHAR_COLON);
    assign c_dec   = is_dec(stage.char_code);
    assign c_hex   = is_hex(stage.char_code);

    // Segment value times ten plus the new digit, by shift and add.
    assign v4_prod = {stage.char_code[0] ? 12'd0 : 12'd0}
                   + {state_reg.v4_value, 3'b000}
                   + {2'b00, state_reg.v4_value, 1'b0}
                   + {8'd0, stage.char_code[3:0]};

    always_comb
    begin
        mid = state_reg;

        if (state_reg.char_count < CHAR_COUNT_SAT)
        begin
            mid.char_count = state_reg.char_count + 6'd1;
        end
        if ((c_dot || c_colon) && (state_reg.sep_count < SEP_COUNT_SAT))
        begin
            mid.sep_count = state_reg.sep_count + 4'd1;
        end

        // Dotted decimal path.
        if (c_dot)
        begin
            if ((state_reg.v4_digits == 2'd0) || (state_reg.v4_value > V4_SEG_MAX))
            begin
                mid.v4_valid = 1'b0;
            end
            mid.v4_value     = 9'd0;
            mid.v4_digits    = 2'd0;
            mid.v4_lead_zero = 1'b0;
        end
        else if (c_dec)
        begin
            if (state_reg.v4_lead_zero)
            begin
                mid.v4_valid = 1'b0;
            end
            if ((state_reg.v4_digits == 2'd0) && (stage.char_code == CHAR_ZERO))
            begin
                mid.v4_lead_zero = 1'b1;
            end
            if (v4_prod > {3'd0, V4_VALUE_SAT})
            begin
                mid.v4_value = V4_VALUE_SAT;
            end
            else
            begin
                mid.v4_value = v4_prod[8:0];
            end
            if (state_reg.v4_digits < V4_DIGITS_SAT)
            begin
                mid.v4_digits = state_reg.v4_digits + 2'd1;
            end
        end
        else
        begin
            mid.v4_valid = 1'b0;
        end

        // Colon hexadecimal path.
        if (c_colon)
        begin
            if ((state_reg.v6_digits == 3'd0) || (state_reg.v6_digits > V6_GROUP_MAX))
            begin
                mid.v6_valid = 1'b0;
            end
            mid.v6_digits = 3'd0;
        end
        else if (c_hex)
        begin
            if (state_reg.v6_digits < V6_DIGITS_SAT)
            begin
                mid.v6_digits = state_reg.v6_digits + 3'd1;
            end
        end
        else
        begin
            mid.v6_valid = 1'b0;
        end
    end

    // The last character also closes the final segment and group.
    assign v4_final_ok = mid.v4_valid && (mid.v4_digits != 2'd0)
                      && (mid.v4_value <= V4_SEG_MAX);
    assign v6_final_ok = mid.v6_valid && (mid.v6_digits != 3'd0)
                      && (mid.v6_digits <= V6_GROUP_MAX);

    always_comb
    begin
        if ((mid.sep_count == V4_SEPARATORS) && (mid.char_count <= V4_MAX_CHARS)
            && v4_final_ok)
        begin
            verdict_next = VERDICT_V4;
        end
        else if ((mid.sep_count == V6_SEPARATORS) && (mid.char_count <= V6_MAX_CHARS)
                 && v6_final_ok)
        begin
            verdict_next = VERDICT_V6;
        end
        else
        begin
            verdict_next = VERDICT_NONE;
        end
    end

    assign state_next = stage.last ? SCAN_RESET : mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ip_address_text_validator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP address text validator
// Judges a character stream as a dotted IPv4 or colon IPv6 address text.
// ----------------------------------------------------------------------------
// The block takes one character request per clock cycle, with last_char set
// on the final character of each text, and gives one verdict request for
// every text: 0 for neither form, 1 for a valid IPv4 address and 2 for a
// valid IPv6 address. A character passes through an input register and then
// through the scanner into the result register, which takes the verdict when
// the last character leaves the input register. Characters that are not last
// leave no result and never wait. A last character waits in the input
// register only while an earlier verdict is still held by out_stall, and
// the input stalls behind it. No gap is needed between texts.
module ip_address_text_validator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict
);
    import ipatv_pkg::*;

    char_stage_t stage;
    logic        advance;
    logic [1:0]  scan_verdict;
    logic        out_free;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  verdict_reg;

    // The result register can take a new verdict when empty or being read.
    assign out_free = !out_valid_reg || !out_stall;

    // A character moves into the scanner unless it would need the result
    // register while that register is still occupied.
    assign advance = stage.valid && (!stage.last || out_free);

    ipatv_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .advance   (advance),
        .stage     (stage)
    );

    ipatv_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .stage        (stage),
        .verdict_next (scan_verdict)
    );

    always_comb
    begin
        if (advance && stage.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The verdict is captured only when a text ends.
    always_ff @(posedge clk)
    begin
        if (advance && stage.last)
        begin
            verdict_reg <= scan_verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule
